// ----- rtl/nlp_pkg.sv -----
`timescale 1ns / 1ps

package nlp_pkg;

  localparam int VALUE_BITS = 32;
  localparam int OUT_BITS   = 32;

  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_F  = 8'h66;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_F  = 8'h46;
  localparam logic [7:0] CH_LC_X  = 8'h78;
  localparam logic [7:0] CH_LC_H  = 8'h68;
  localparam logic [7:0] CH_LC_B  = 8'h62;
  localparam logic [7:0] CH_MINUS = 8'h2d;

  localparam logic [3:0] HEX_LETTER_OFS = 4'd9;

  typedef enum logic [1:0] {
    RX_DEC = 2'd0,
    RX_HEX = 2'd1,
    RX_BIN = 2'd2
  } radix_t;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] value;
    logic                       error;
  } nlp_res_t;

endpackage

// ----- rtl/nlp_core.sv -----
`timescale 1ns / 1ps

module nlp_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_i,
  input  logic [7:0]          char_i,
  input  logic                last_i,
  output nlp_pkg::nlp_res_t   res_o
);

  typedef enum logic [1:0] {
    PH_START,
    PH_ZERO,
    PH_DIGITS,
    PH_DONE
  } phase_t;

  phase_t                          phase_r, phase_nxt;
  nlp_pkg::radix_t                 radix_r, radix_nxt;
  logic                            neg_r, neg_nxt;
  logic                            bad_r, bad_nxt;
  logic [nlp_pkg::VALUE_BITS-1:0]  acc_r, acc_nxt;

  logic                            is_dec;
  logic                            is_hex_letter;
  logic                            dig_ok;
  logic [3:0]                      dig_val;
  logic [nlp_pkg::VALUE_BITS-1:0]  acc_mul;
  logic [nlp_pkg::VALUE_BITS-1:0]  acc_step;
  logic [nlp_pkg::VALUE_BITS-1:0]  acc_signed;

  // digit decode for the current radix
  always_comb begin
    is_dec        = (char_i >= nlp_pkg::CH_0) && (char_i <= nlp_pkg::CH_9);
    is_hex_letter = ((char_i >= nlp_pkg::CH_LC_A) && (char_i <= nlp_pkg::CH_LC_F)) ||
                    ((char_i >= nlp_pkg::CH_UC_A) && (char_i <= nlp_pkg::CH_UC_F));
    dig_val       = is_dec ? char_i[3:0] : 4'(char_i[3:0] + nlp_pkg::HEX_LETTER_OFS);
    case (radix_r)
      nlp_pkg::RX_BIN: dig_ok = (char_i == nlp_pkg::CH_0) || (char_i == nlp_pkg::CH_1);
      nlp_pkg::RX_HEX: dig_ok = is_dec || is_hex_letter;
      default:         dig_ok = is_dec;
    endcase
  end

  // constant-radix multiply-add as shifts
  always_comb begin
    case (radix_r)
      nlp_pkg::RX_HEX: acc_mul = acc_r << 4;
      nlp_pkg::RX_BIN: acc_mul = acc_r << 1;
      default:         acc_mul = (acc_r << 3) + (acc_r << 1);
    endcase
    acc_step = acc_mul + nlp_pkg::VALUE_BITS'(dig_val);
  end

  always_comb begin
    phase_nxt = phase_r;
    radix_nxt = radix_r;
    neg_nxt   = neg_r;
    bad_nxt   = bad_r;
    acc_nxt   = acc_r;
    case (phase_r)
      PH_START: begin
        acc_nxt = '0;
        if (char_i == nlp_pkg::CH_0) begin
          radix_nxt = nlp_pkg::RX_DEC;
          phase_nxt = PH_ZERO;
        end else if (char_i == nlp_pkg::CH_LC_H) begin
          radix_nxt = nlp_pkg::RX_HEX;
          phase_nxt = PH_DIGITS;
        end else if (char_i == nlp_pkg::CH_LC_B) begin
          radix_nxt = nlp_pkg::RX_BIN;
          phase_nxt = PH_DIGITS;
        end else if (char_i == nlp_pkg::CH_MINUS) begin
          radix_nxt = nlp_pkg::RX_DEC;
          neg_nxt   = 1'b1;
          phase_nxt = PH_DIGITS;
        end else if (is_dec) begin
          radix_nxt = nlp_pkg::RX_DEC;
          acc_nxt   = nlp_pkg::VALUE_BITS'(char_i[3:0]);
          phase_nxt = PH_DIGITS;
        end else begin
          bad_nxt   = 1'b1;
          phase_nxt = PH_DONE;
        end
      end
      PH_ZERO: begin
        if (char_i == nlp_pkg::CH_LC_X) begin
          radix_nxt = nlp_pkg::RX_HEX;
          phase_nxt = PH_DIGITS;
        end else if (is_dec) begin
          acc_nxt   = nlp_pkg::VALUE_BITS'(char_i[3:0]);
          phase_nxt = PH_DIGITS;
        end else begin
          phase_nxt = PH_DONE;
        end
      end
      PH_DIGITS: begin
        if (dig_ok) begin
          acc_nxt = acc_step;
        end else begin
          phase_nxt = PH_DONE;
        end
      end
      default: begin
      end
    endcase
  end

  // final value for a word marked last
  always_comb begin
    acc_signed  = neg_nxt ? (~acc_nxt + 1'b1) : acc_nxt;
    res_o.value = bad_nxt ? '0 : nlp_pkg::OUT_BITS'(signed'(acc_signed));
    res_o.error = bad_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      radix_r <= nlp_pkg::RX_DEC;
      neg_r   <= 1'b0;
      bad_r   <= 1'b0;
      acc_r   <= '0;
    end else if (step_i) begin
      if (last_i) begin
        phase_r <= PH_START;
        radix_r <= nlp_pkg::RX_DEC;
        neg_r   <= 1'b0;
        bad_r   <= 1'b0;
        acc_r   <= '0;
      end else begin
        phase_r <= phase_nxt;
        radix_r <= radix_nxt;
        neg_r   <= neg_nxt;
        bad_r   <= bad_nxt;
        acc_r   <= acc_nxt;
      end
    end
  end

`ifndef ASSERT_OFF
  a_bad_is_done: assert property (@(posedge clk) disable iff (!rst_n)
    bad_r |-> (phase_r == PH_DONE))
    else $error("bad start outside done phase");

  a_start_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_START) |-> (acc_r == '0 && !neg_r && radix_r == nlp_pkg::RX_DEC))
    else $error("token start with stale state");

  a_bin_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (radix_r == nlp_pkg::RX_BIN) |-> (phase_r == PH_DIGITS || phase_r == PH_DONE))
    else $error("binary radix in wrong phase");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (step_i && last_i) |=> (phase_r == PH_START))
    else $error("token not cleared after last word");
`endif

endmodule

// ----- rtl/numeric_literal_parser.sv -----
`timescale 1ns / 1ps

// channel  ports                              direction
// in       in_valid in_stall in_char_code in_last    word in, one character
// out      out_valid out_stall out_value out_error   word out, one per token
//
// one character is taken every cycle unless in_stall is high; a token's result
// passes through the input register, then the result register.
// the running value is updated by one shift-add per character in nlp_core.
// rst_n is synchronous and clears the token state and both valid flags.
// a stalled result holds only a following last character back; other
// characters keep flowing into the token state.

module numeric_literal_parser (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [7:0]                          in_char_code,
  input  logic                                in_last,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [nlp_pkg::OUT_BITS-1:0] out_value,
  output logic                                out_error
);

  logic                               in_vld_r;
  logic [7:0]                         in_char_r;
  logic                               in_last_r;
  logic                               advance;

  logic                               out_vld_r;
  logic signed [nlp_pkg::OUT_BITS-1:0] out_value_r;
  logic                               out_error_r;

  nlp_pkg::nlp_res_t                  res;

  assign advance  = in_vld_r && (!in_last_r || !out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_char_r <= in_char_code;
      in_last_r <= in_last;
    end
  end

  nlp_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step_i (advance),
    .char_i (in_char_r),
    .last_i (in_last_r),
    .res_o  (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance && in_last_r) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last_r) begin
      out_value_r <= res.value;
      out_error_r <= res.error;
    end
  end

  assign out_valid = out_vld_r;
  assign out_value = out_value_r;
  assign out_error = out_error_r;

endmodule
